/* hdl/lpm_pkg.sv */
// Shared types, codes and constants of the laser power modulator.
package lpm_pkg;

  // Serial divider geometry: dividend, divisor and step counter widths.
  localparam int DIV_W = 53;
  localparam int DEN_W = 24;
  localparam int CNT_W = 6;

  // Dividend alignment and step counts of the three divisions.
  localparam logic [CNT_W-1:0] REQ_STEPS  = 6'd29;
  localparam logic [CNT_W-1:0] RATE_STEPS = 6'd53;
  localparam logic [CNT_W-1:0] MS_STEPS   = 6'd24;

  localparam logic [6:0]  PCT_FULL   = 7'd100;
  // 65536 / 100 scaled by 2^12 and rounded up; exact floor for 0..100 percent.
  localparam logic [21:0] PCT_RECIP  = 22'd2684355;
  localparam logic [15:0] DUTY_FULL  = 16'hFFFF;
  localparam logic [32:0] SAT_LIMIT  = 33'h1_0000_0000;

  // Input item kinds.
  localparam logic [1:0] FUNC_TICK = 2'd0;
  localparam logic [1:0] FUNC_FIRE = 2'd1;
  localparam logic [1:0] FUNC_HALT = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_SHORT   = 2'd1;
  localparam logic [1:0] ST_HALTED  = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] CFG_MAX_POWER  = 3'd0;
  localparam logic [2:0] CFG_MIN_POWER  = 3'd1;
  localparam logic [2:0] CFG_MAX_S      = 3'd2;
  localparam logic [2:0] CFG_SCALE      = 3'd3;
  localparam logic [2:0] CFG_AUTO_OFF   = 3'd4;
  localparam logic [2:0] CFG_INVERT     = 3'd5;
  localparam logic [2:0] CFG_TTL        = 3'd6;
  localparam logic [2:0] CFG_TICK_MS    = 3'd7;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_QUICK,
    OP_START_REQ,
    OP_TAKE_REQ,
    OP_MUL_RATE,
    OP_START_RATE,
    OP_TAKE_PROD,
    OP_MUL_SCALE,
    OP_MUL_DIFF,
    OP_MAP,
    OP_START_MS,
    OP_TAKE_MS,
    OP_TAKE_PCT,
    OP_PUBLISH
  } lpm_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_REQ_WAIT,
    S_MUL_RATE,
    S_RATE_START,
    S_RATE_WAIT,
    S_MUL_SCALE,
    S_MUL_DIFF,
    S_MAP,
    S_MS_WAIT,
    S_PCT_TAKE,
    S_DONE
  } lpm_state_t;

  typedef struct packed {
    logic auto_go;
    logic fire_go;
    logic bypass;
    logic div_done;
  } lpm_stat_t;

endpackage

/* hdl/laser_power_modulator_unit.sv */
// Top level of the laser power modulator: controller, datapath and ports.
//
// Input items carry a tick, a manual fire command or a halt change, taken
// over a valid/ready channel. Every item yields exactly one result item on
// the out_ channel: the PWM duty (Q0.16, inverted if so configured), the
// laser enable, the TTL level, the manual mode flag and a status code. The
// user must write configuration registers (cfg_we, cfg_index, cfg_wdata)
// only while the block is idle (unenforced); writes take effect at once.
//
// One item is worked on at a time. A tick that computes auto power runs the
// shared serial divider twice: 29 steps for the S ratio and 53 for the
// speed ratio. With the speed ratio taken as one the second division is
// skipped. A valid fire command runs 24 divider steps for the duration.
// Every other item goes straight from its decision to publishing. The next
// item can be accepted in the cycle after a result is published.
//
// A finished result sits in an output register; the next item is accepted
// while it waits, and its own result is held until the receiver takes the
// pending one. Reset (synchronous, active low) restores the default
// configuration, turns the laser off and clears manual mode and halt.
module laser_power_modulator_unit import lpm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic        in_move_active,
  input  logic [15:0] in_s_request,
  input  logic [23:0] in_actuator_rate,
  input  logic [23:0] in_nominal_rate,
  input  logic [7:0]  in_fire_percent,
  input  logic [23:0] in_fire_ms,
  input  logic        in_halt_flag,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_pwm_duty,
  output logic        out_laser_enabled,
  output logic        out_ttl_level,
  output logic        out_manual_mode,
  output logic [1:0]  out_status
);

  lpm_op_t   op;
  lpm_stat_t stat;

  // The controller only sequences; all arithmetic, configuration and laser state live below.
  lpm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .op        (op)
  );

  lpm_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .op                (op),
    .stat              (stat),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_func           (in_func),
    .in_move_active    (in_move_active),
    .in_s_request      (in_s_request),
    .in_actuator_rate  (in_actuator_rate),
    .in_nominal_rate   (in_nominal_rate),
    .in_fire_percent   (in_fire_percent),
    .in_fire_ms        (in_fire_ms),
    .in_halt_flag      (in_halt_flag),
    .out_pwm_duty      (out_pwm_duty),
    .out_laser_enabled (out_laser_enabled),
    .out_ttl_level     (out_ttl_level),
    .out_manual_mode   (out_manual_mode),
    .out_status        (out_status)
  );

endmodule

/* hdl/lpm_div.sv */
// Restoring serial divider, one quotient bit per cycle.
module lpm_div import lpm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  input  logic [CNT_W-1:0] steps,
  output logic             done,
  output logic [DIV_W-1:0] quotient,
  output logic [DEN_W-1:0] remainder
);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DIV_W-1:0] q_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] d_r;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_sub;
  logic             fits;

  // The dividend sits left aligned, so its top bit enters the remainder first.
  assign rem_sh  = {rem_r, q_r[DIV_W-1]};
  assign rem_sub = rem_sh - {1'b0, d_r};
  assign fits    = rem_sh >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      d_r   <= divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[DIV_W-2:0], fits};
      rem_r <= fits ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    end
  end

  assign done      = done_r;
  assign quotient  = q_r;
  assign remainder = rem_r;

endmodule

/* hdl/lpm_dp.sv */
// Datapath: configuration, laser state, power arithmetic and result register.
module lpm_dp import lpm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  lpm_op_t     op,
  output lpm_stat_t   stat,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic [1:0]  in_func,
  input  logic        in_move_active,
  input  logic [15:0] in_s_request,
  input  logic [23:0] in_actuator_rate,
  input  logic [23:0] in_nominal_rate,
  input  logic [7:0]  in_fire_percent,
  input  logic [23:0] in_fire_ms,
  input  logic        in_halt_flag,
  output logic [15:0] out_pwm_duty,
  output logic        out_laser_enabled,
  output logic        out_ttl_level,
  output logic        out_manual_mode,
  output logic [1:0]  out_status
);

  // Configuration registers.
  logic [15:0] max_power_r, min_power_r, max_s_r, scale_r;
  logic        auto_off_r, invert_r, ttl_r;
  logic [9:0]  tick_ms_r;

  // Laser state.
  logic        laser_is_on_r, manual_active_r, halted_r;
  logic [23:0] remaining_ms_r;
  logic [15:0] duty_now_r;
  logic [1:0]  status_r;

  // Latched item.
  logic [1:0]  func_r;
  logic        move_r, halt_flag_r;
  logic [15:0] s_r;
  logic [23:0] rate_r, nominal_r, ms_r;
  logic [7:0]  pct_r;

  // Intermediate results.
  logic [28:0]        req_r;
  logic [52:0]        mul_r;
  logic [32:0]        prod_r;
  logic [32:0]        p_r;
  logic signed [50:0] sp_r;

  // Result register.
  logic [15:0] res_duty_r;
  logic        res_on_r, res_ttl_r, res_manual_r;
  logic [1:0]  res_status_r;

  logic [9:0]        t_len;
  logic [15:0]       m_eff;
  logic [6:0]        pct_c;
  logic              ms_short;
  logic              div_start;
  logic [DIV_W-1:0]  div_dividend;
  logic [DEN_W-1:0]  div_divisor;
  logic [CNT_W-1:0]  div_steps;
  logic              div_done;
  logic [DIV_W-1:0]  div_q;
  logic [DEN_W-1:0]  div_rem;
  logic [48:0]       scaled;
  logic [36:0]       scaled_sh;
  logic signed [16:0] diff;
  logic signed [50:0] sp_adj;
  logic signed [34:0] quo;
  logic signed [35:0] mapped;
  logic [15:0]       map_duty;
  logic [28:0]       pct_prod;
  logic [15:0]       pct_duty;

  assign t_len    = (tick_ms_r == 10'd0) ? 10'd1 : tick_ms_r;
  assign m_eff    = (max_s_r == 16'd0) ? 16'd1 : max_s_r;
  assign pct_c    = (pct_r > 8'd100) ? PCT_FULL : pct_r[6:0];
  assign ms_short = (ms_r != 24'd0) && (ms_r < {14'd0, t_len});

  assign stat.auto_go  = (func_r == FUNC_TICK) && !manual_active_r && move_r;
  assign stat.fire_go  = (func_r == FUNC_FIRE) && !halted_r && (pct_r != 8'd0) && !ms_short;
  assign stat.bypass   = auto_off_r || (nominal_r == 24'd0);
  assign stat.div_done = div_done;

  always_comb begin
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    div_steps    = '0;
    case (op)
      OP_START_REQ: begin
        div_start    = 1'b1;
        div_dividend = {s_r, 37'd0};
        div_divisor  = {8'd0, m_eff};
        div_steps    = REQ_STEPS;
      end
      OP_START_RATE: begin
        div_start    = 1'b1;
        div_dividend = mul_r;
        div_divisor  = nominal_r;
        div_steps    = RATE_STEPS;
      end
      OP_START_MS: begin
        div_start    = 1'b1;
        div_dividend = {ms_r, 29'd0};
        div_divisor  = {14'd0, t_len};
        div_steps    = MS_STEPS;
      end
      default: begin
      end
    endcase
  end

  lpm_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .steps     (div_steps),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_rem)
  );

  // Scale by Q4.12 factor, saturate the Q16 power at 2^32 (65536.0).
  assign scaled    = prod_r * scale_r;
  assign scaled_sh = scaled[48:12];

  // Map into min..max with the quotient truncated toward zero, then clamp.
  assign diff   = $signed({1'b0, max_power_r}) - $signed({1'b0, min_power_r});
  assign sp_adj = sp_r[50] ? (sp_r + 51'sd65535) : sp_r;
  assign quo    = sp_adj[50:16];
  assign mapped = $signed({20'd0, min_power_r}) + {quo[34], quo};

  always_comb begin
    if (mapped[35]) begin
      map_duty = 16'd0;
    end else if (mapped > 36'sd65535) begin
      map_duty = DUTY_FULL;
    end else begin
      map_duty = mapped[15:0];
    end
  end

  // Manual power: percent times 65536 / 100 by a reciprocal multiplication.
  assign pct_prod = {22'd0, pct_c} * PCT_RECIP;
  assign pct_duty = (pct_prod[28:12] > {1'b0, DUTY_FULL}) ? DUTY_FULL : pct_prod[27:12];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_power_r     <= DUTY_FULL;
      min_power_r     <= 16'd0;
      max_s_r         <= 16'd256;
      scale_r         <= 16'd4096;
      auto_off_r      <= 1'b0;
      invert_r        <= 1'b0;
      ttl_r           <= 1'b0;
      tick_ms_r       <= 10'd1;
      laser_is_on_r   <= 1'b0;
      manual_active_r <= 1'b0;
      halted_r        <= 1'b0;
      remaining_ms_r  <= 24'd0;
      duty_now_r      <= 16'd0;
      status_r        <= ST_DONE;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MAX_POWER: max_power_r <= cfg_wdata;
          CFG_MIN_POWER: min_power_r <= cfg_wdata;
          CFG_MAX_S:     max_s_r     <= cfg_wdata;
          CFG_SCALE:     scale_r     <= cfg_wdata;
          CFG_AUTO_OFF:  auto_off_r  <= cfg_wdata[0];
          CFG_INVERT:    invert_r    <= cfg_wdata[0];
          CFG_TTL:       ttl_r       <= cfg_wdata[0];
          CFG_TICK_MS:   tick_ms_r   <= cfg_wdata[9:0];
          default: begin
          end
        endcase
      end
      case (op)
        OP_LOAD: status_r <= ST_DONE;
        OP_QUICK: begin
          case (func_r)
            FUNC_TICK: begin
              if (manual_active_r) begin
                if (remaining_ms_r != 24'd0) begin
                  if (remaining_ms_r <= {14'd0, t_len}) begin
                    laser_is_on_r   <= 1'b0;
                    duty_now_r      <= 16'd0;
                    manual_active_r <= 1'b0;
                    remaining_ms_r  <= 24'd0;
                  end else begin
                    remaining_ms_r <= remaining_ms_r - {14'd0, t_len};
                  end
                end
              end else begin
                // No move this tick: the laser goes off.
                laser_is_on_r <= 1'b0;
                duty_now_r    <= 16'd0;
              end
            end
            FUNC_FIRE: begin
              if (halted_r) begin
                status_r <= ST_HALTED;
              end else if (pct_r == 8'd0) begin
                laser_is_on_r   <= 1'b0;
                duty_now_r      <= 16'd0;
                manual_active_r <= 1'b0;
                remaining_ms_r  <= 24'd0;
              end else begin
                // Duration shorter than a tick: kept, but the fire is refused.
                remaining_ms_r <= ms_r;
                status_r       <= ST_SHORT;
              end
            end
            FUNC_HALT: begin
              if (halt_flag_r) begin
                laser_is_on_r   <= 1'b0;
                duty_now_r      <= 16'd0;
                manual_active_r <= 1'b0;
                halted_r        <= 1'b1;
              end else begin
                halted_r <= 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
        OP_MAP: begin
          duty_now_r    <= map_duty;
          laser_is_on_r <= (map_duty != 16'd0);
        end
        OP_TAKE_MS: remaining_ms_r <= ms_r - div_rem;
        OP_TAKE_PCT: begin
          duty_now_r      <= pct_duty;
          laser_is_on_r   <= (pct_duty != 16'd0);
          manual_active_r <= (pct_duty != 16'd0);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        func_r      <= in_func;
        move_r      <= in_move_active;
        s_r         <= in_s_request;
        rate_r      <= in_actuator_rate;
        nominal_r   <= in_nominal_rate;
        pct_r       <= in_fire_percent;
        ms_r        <= in_fire_ms;
        halt_flag_r <= in_halt_flag;
      end
      OP_TAKE_REQ: begin
        req_r  <= div_q[28:0];
        prod_r <= {4'd0, div_q[28:0]};
      end
      OP_MUL_RATE: mul_r <= req_r * rate_r;
      OP_TAKE_PROD: prod_r <= (div_q > {20'd0, SAT_LIMIT}) ? SAT_LIMIT : div_q[32:0];
      OP_MUL_SCALE: p_r <= (scaled_sh > {4'd0, SAT_LIMIT}) ? SAT_LIMIT : scaled_sh[32:0];
      OP_MUL_DIFF: sp_r <= diff * $signed({1'b0, p_r});
      OP_PUBLISH: begin
        res_duty_r   <= invert_r ? ~duty_now_r : duty_now_r;
        res_on_r     <= laser_is_on_r;
        res_ttl_r    <= ttl_r && laser_is_on_r;
        res_manual_r <= manual_active_r;
        res_status_r <= status_r;
      end
      default: begin
      end
    endcase
  end

  assign out_pwm_duty      = res_duty_r;
  assign out_laser_enabled = res_on_r;
  assign out_ttl_level     = res_ttl_r;
  assign out_manual_mode   = res_manual_r;
  assign out_status        = res_status_r;

  // The on flag always agrees with the stored duty.
  a_on_matches_duty: assert property (@(posedge clk) disable iff (!rst_n)
    laser_is_on_r == (duty_now_r != 16'd0))
    else $error("laser on flag disagrees with duty");

  // Manual fire never runs with the laser off or while halted.
  a_manual_on: assert property (@(posedge clk) disable iff (!rst_n)
    manual_active_r |-> (laser_is_on_r && !halted_r))
    else $error("manual fire without laser on");

  // Entering halt always leaves the laser off.
  a_halt_off: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(halted_r) |-> !laser_is_on_r)
    else $error("halt entered with laser on");

endmodule

/* hdl/lpm_ctrl.sv */
// Controller state machine sequencing the datapath for each item.
module lpm_ctrl import lpm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  lpm_stat_t stat,
  output lpm_op_t   op
);

  lpm_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    op        = OP_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op        = OP_LOAD;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.auto_go) begin
          op        = OP_START_REQ;
          state_nxt = S_REQ_WAIT;
        end else if (stat.fire_go) begin
          op        = OP_START_MS;
          state_nxt = S_MS_WAIT;
        end else begin
          op        = OP_QUICK;
          state_nxt = S_DONE;
        end
      end
      S_REQ_WAIT: begin
        if (stat.div_done) begin
          op        = OP_TAKE_REQ;
          state_nxt = stat.bypass ? S_MUL_SCALE : S_MUL_RATE;
        end
      end
      S_MUL_RATE: begin
        op        = OP_MUL_RATE;
        state_nxt = S_RATE_START;
      end
      S_RATE_START: begin
        op        = OP_START_RATE;
        state_nxt = S_RATE_WAIT;
      end
      S_RATE_WAIT: begin
        if (stat.div_done) begin
          op        = OP_TAKE_PROD;
          state_nxt = S_MUL_SCALE;
        end
      end
      S_MUL_SCALE: begin
        op        = OP_MUL_SCALE;
        state_nxt = S_MUL_DIFF;
      end
      S_MUL_DIFF: begin
        op        = OP_MUL_DIFF;
        state_nxt = S_MAP;
      end
      S_MAP: begin
        op        = OP_MAP;
        state_nxt = S_DONE;
      end
      S_MS_WAIT: begin
        if (stat.div_done) begin
          op        = OP_TAKE_MS;
          state_nxt = S_PCT_TAKE;
        end
      end
      S_PCT_TAKE: begin
        op        = OP_TAKE_PCT;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          op        = OP_PUBLISH;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (op == OP_PUBLISH) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

/* tb/laser_power_modulator_unit_checker.sv */
// Result checker for the laser power modulator: predicts each result and compares it.
`timescale 1ns / 100ps

module laser_power_modulator_unit_checker import lpm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic        in_move_active,
  input  logic [15:0] in_s_request,
  input  logic [23:0] in_actuator_rate,
  input  logic [23:0] in_nominal_rate,
  input  logic [7:0]  in_fire_percent,
  input  logic [23:0] in_fire_ms,
  input  logic        in_halt_flag,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [15:0] out_pwm_duty,
  input  logic        out_laser_enabled,
  input  logic        out_ttl_level,
  input  logic        out_manual_mode,
  input  logic [1:0]  out_status,
  output int          fail_count,
  output int          pending_count
);

  typedef struct packed {
    logic [15:0] duty;
    logic        enabled;
    logic        ttl;
    logic        manual;
    logic [1:0]  status;
  } laser_out_t;

  laser_out_t laser_queue[$];

  // Shadow configuration.
  logic [15:0] max_pwr, min_pwr, max_s, scale;
  logic        auto_off, invert, ttl_on;
  logic [9:0]  tick_len_ms;

  // Shadow state.
  logic        lit, manual, halted;
  logic [23:0] remain_ms;
  logic [15:0] duty_raw;

  function automatic logic [15:0] auto_power(input logic [15:0] s, input logic [23:0] rate,
                                             input logic [23:0] nom);
    logic [63:0] m, req, prod, p;
    longint diff, mapped;
    m = (max_s == 0) ? 64'd1 : 64'(max_s);
    req = (64'(s) << 13) / m;
    prod = req;
    if (!auto_off && nom != 0) prod = (req * 64'(rate)) / 64'(nom);
    if (prod > 64'h1_0000_0000) prod = 64'h1_0000_0000;
    p = (prod * 64'(scale)) >> 12;
    if (p > 64'h1_0000_0000) p = 64'h1_0000_0000;
    diff = longint'(max_pwr) - longint'(min_pwr);
    mapped = longint'(min_pwr) + (diff * longint'(p)) / 65536;
    if (mapped < 0) mapped = 0;
    if (mapped > 65535) mapped = 65535;
    return 16'(mapped);
  endfunction

  task automatic set_power(input logic [31:0] d);
    if (d > 32'hFFFF) d = 32'hFFFF;
    lit = (d != 0);
    duty_raw = d[15:0];
  endtask

  task automatic predict_laser();
    logic [1:0]  st;
    logic [23:0] t;
    logic [31:0] pct;
    st = ST_DONE;
    t = (tick_len_ms == 0) ? 24'd1 : 24'(tick_len_ms);
    case (in_func)
      FUNC_TICK: begin
        if (manual) begin
          if (remain_ms > 0) begin
            if (remain_ms <= t) begin
              set_power(0);
              manual = 1'b0;
              remain_ms = 0;
            end else begin
              remain_ms = remain_ms - t;
            end
          end
        end else if (in_move_active) begin
          set_power(32'(auto_power(in_s_request, in_actuator_rate, in_nominal_rate)));
        end else if (lit) begin
          set_power(0);
        end
      end
      FUNC_FIRE: begin
        if (halted) begin
          st = ST_HALTED;
        end else begin
          remain_ms = 0;
          if (in_fire_percent == 0) begin
            set_power(0);
            manual = 1'b0;
          end else begin
            pct = (in_fire_percent > 100) ? 32'd100 : 32'(in_fire_percent);
            if (in_fire_ms != 0) remain_ms = in_fire_ms;
            if (in_fire_ms != 0 && in_fire_ms < t) begin
              st = ST_SHORT;
            end else begin
              if (in_fire_ms != 0) remain_ms = (in_fire_ms / t) * t;
              set_power((pct * 65536) / 100);
              manual = lit;
            end
          end
        end
      end
      FUNC_HALT: begin
        if (in_halt_flag) begin
          set_power(0);
          manual = 1'b0;
          halted = 1'b1;
        end else begin
          halted = 1'b0;
        end
      end
      default: ;
    endcase
    laser_queue.push_back('{invert ? 16'hFFFF - duty_raw : duty_raw, lit, ttl_on && lit,
                            manual, st});
  endtask

  always @(posedge clk) begin
    laser_out_t exp_res;
    if (!rst_n) begin
      max_pwr <= 16'hFFFF; min_pwr <= 0; max_s <= 16'd256; scale <= 16'd4096;
      auto_off <= 0; invert <= 0; ttl_on <= 0; tick_len_ms <= 10'd1;
      lit = 0; manual = 0; halted = 0; remain_ms = 0; duty_raw = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MAX_POWER: max_pwr <= cfg_wdata;
          CFG_MIN_POWER: min_pwr <= cfg_wdata;
          CFG_MAX_S:     max_s <= cfg_wdata;
          CFG_SCALE:     scale <= cfg_wdata;
          CFG_AUTO_OFF:  auto_off <= cfg_wdata[0];
          CFG_INVERT:    invert <= cfg_wdata[0];
          CFG_TTL:       ttl_on <= cfg_wdata[0];
          CFG_TICK_MS:   tick_len_ms <= cfg_wdata[9:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) predict_laser();
      if (out_valid && out_ready) begin
        if (laser_queue.size() == 0) begin
          $error("result without an expected item");
          fail_count++;
        end else begin
          exp_res = laser_queue.pop_front();
          if (out_pwm_duty !== exp_res.duty) begin
            $error("pwm_duty expected %0d actual %0d", exp_res.duty, out_pwm_duty);
            fail_count++;
          end
          if (out_laser_enabled !== exp_res.enabled) begin
            $error("laser_enabled expected %0d actual %0d", exp_res.enabled,
                   out_laser_enabled);
            fail_count++;
          end
          if (out_ttl_level !== exp_res.ttl) begin
            $error("ttl_level expected %0d actual %0d", exp_res.ttl, out_ttl_level);
            fail_count++;
          end
          if (out_manual_mode !== exp_res.manual) begin
            $error("manual_mode expected %0d actual %0d", exp_res.manual, out_manual_mode);
            fail_count++;
          end
          if (out_status !== exp_res.status) begin
            $error("status expected %0d actual %0d", exp_res.status, out_status);
            fail_count++;
          end
        end
      end
    end
    pending_count = laser_queue.size();
  end

endmodule

/* tb/laser_power_modulator_unit_test.sv */
// Testbench top for the laser power modulator: stimulus, clock, reset and verdict.
`timescale 1ns / 100ps

module laser_power_modulator_unit_test import lpm_pkg::*; ();

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = CFG_MAX_POWER;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_func = FUNC_TICK;
  logic        in_move_active = 1'b0;
  logic [15:0] in_s_request = '0;
  logic [23:0] in_actuator_rate = '0;
  logic [23:0] in_nominal_rate = 24'd1;
  logic [7:0]  in_fire_percent = '0;
  logic [23:0] in_fire_ms = '0;
  logic        in_halt_flag = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_pwm_duty;
  logic        out_laser_enabled;
  logic        out_ttl_level;
  logic        out_manual_mode;
  logic [1:0]  out_status;
  int          fail_count;
  int          pending_count;
  // When set, the receiver holds off for a long stretch so the block backs up.
  logic        hold_request = 1'b0;

  always #4 clk = ~clk;

  laser_power_modulator_unit i_dut (.*);
  laser_power_modulator_unit_checker i_checker (.*);

  // Sends one item and waits until the block takes it. Valid stays high
  // across back-to-back items; a random gap follows when a burst ends.
  // Ready only changes at rising edges, so its value at the falling edge
  // tells whether the next rising edge accepts the item.
  task automatic send_item(input logic [1:0] func, input logic move, input logic [15:0] s,
                           input logic [23:0] rate, input logic [23:0] nom,
                           input logic [7:0] pct, input logic [23:0] ms,
                           input logic halt);
    in_valid <= 1'b1;
    in_func <= func;
    in_move_active <= move;
    in_s_request <= s;
    in_actuator_rate <= rate;
    in_nominal_rate <= nom;
    in_fire_percent <= pct;
    in_fire_ms <= ms;
    in_halt_flag <= halt;
    while (!in_ready) @(negedge clk);
    @(negedge clk);
    if ($urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(negedge clk);
    end
  endtask

  // Drops valid and waits until every result is back and the block is idle.
  task automatic drain_block();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_count != 0) @(negedge clk);
    repeat (120) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // A random item, weighted toward ticks with moves and valid fire commands.
  task automatic random_item();
    logic [1:0]  func;
    logic [23:0] ms;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) func = FUNC_TICK;
    else if (pick < 85) func = FUNC_FIRE;
    else if (pick < 97) func = FUNC_HALT;
    else func = 2'd3;
    case ($urandom_range(0, 3))
      0: ms = 24'd0;
      1: ms = 24'($urandom_range(1, 40));
      2: ms = 24'($urandom_range(1, 5000));
      default: ms = 24'($urandom);
    endcase
    send_item(func, $urandom_range(0, 5) != 0, 16'($urandom),
              ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 2000)),
              ($urandom_range(0, 9) == 0) ? 24'($urandom) : 24'($urandom_range(0, 2000)),
              ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 100)),
              ms, $urandom_range(0, 2) == 0);
  endtask

  // Receiver: random stalls, quiet stretches, and one long hold-off on request.
  initial begin
    int   hold_cycles;
    logic held;
    held = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && !held) begin
        out_ready <= 1'b0;
        for (hold_cycles = 0; hold_cycles < 600; hold_cycles++) @(negedge clk);
        held = 1'b1;
      end
      if ($urandom_range(0, 99) < 15) out_ready <= 1'b1;
      else out_ready <= ($urandom_range(0, 2) != 0);
    end
  end

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part under reset defaults, then a few register settings.
    send_item(FUNC_TICK, 1'b1, 16'd2048, 24'd100, 24'd100, 8'd0, 24'd0, 1'b0);
    send_item(FUNC_TICK, 1'b1, 16'hFFFF, 24'hFFFFFF, 24'd1, 8'd0, 24'd0, 1'b0);
    send_item(FUNC_TICK, 1'b1, 16'd0, 24'd5, 24'd0, 8'd0, 24'd0, 1'b0);
    send_item(FUNC_TICK, 1'b0, 16'd0, 24'd0, 24'd1, 8'd0, 24'd0, 1'b0);
    send_item(FUNC_TICK, 1'b0, 16'd0, 24'd0, 24'd1, 8'd0, 24'd0, 1'b0);
    send_item(FUNC_FIRE, 1'b0, 16'd0, 24'd0, 24'd1, 8'd255, 24'd3, 1'b0);
    send_item(FUNC_TICK, 1'b1, 16'd1000, 24'd1, 24'd1, 8'd0, 24'd0, 1'b0);
    send_item(FUNC_TICK, 1'b0, 16'd0, 24'd0, 24'd1, 8'd0, 24'd0, 1'b0);
    send_item(FUNC_TICK, 1'b0, 16'd0, 24'd0, 24'd1, 8'd0, 24'd0, 1'b0);
    send_item(FUNC_FIRE, 1'b0, 16'd0, 24'd0, 24'd1, 8'd50, 24'd0, 1'b0);
    send_item(FUNC_FIRE, 1'b0, 16'd0, 24'd0, 24'd1, 8'd0, 24'hFFFFFF, 1'b0);
    send_item(FUNC_HALT, 1'b0, 16'd0, 24'd0, 24'd1, 8'd0, 24'd0, 1'b1);
    send_item(FUNC_FIRE, 1'b0, 16'd0, 24'd0, 24'd1, 8'd80, 24'd9, 1'b0);
    send_item(FUNC_HALT, 1'b0, 16'd0, 24'd0, 24'd1, 8'd0, 24'd0, 1'b0);
    send_item(2'd3, 1'b1, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 8'hFF, 24'hFFFFFF, 1'b1);
    drain_block();

    // Extreme settings: zero max S and tick, inverted duty, TTL, min above max.
    write_reg(CFG_MAX_S, 16'd0);
    write_reg(CFG_TICK_MS, 16'd0);
    write_reg(CFG_INVERT, 16'd1);
    write_reg(CFG_TTL, 16'd1);
    write_reg(CFG_MIN_POWER, 16'hFFFF);
    write_reg(CFG_MAX_POWER, 16'd0);
    write_reg(CFG_SCALE, 16'hFFFF);
    send_item(FUNC_TICK, 1'b1, 16'd1, 24'd1, 24'd3, 8'd0, 24'd0, 1'b0);
    send_item(FUNC_TICK, 1'b1, 16'hFFFF, 24'hFFFFFF, 24'd1, 8'd0, 24'd0, 1'b0);
    drain_block();
    write_reg(CFG_TICK_MS, 16'd1000);
    write_reg(CFG_AUTO_OFF, 16'd1);
    send_item(FUNC_TICK, 1'b1, 16'd300, 24'd7, 24'd9, 8'd0, 24'd0, 1'b0);
    // A running fire is started, a short duration is then stored, and ticks count it down.
    send_item(FUNC_FIRE, 1'b0, 16'd0, 24'd0, 24'd1, 8'd30, 24'd2500, 1'b0);
    send_item(FUNC_FIRE, 1'b0, 16'd0, 24'd0, 24'd1, 8'd30, 24'd999, 1'b0);
    send_item(FUNC_TICK, 1'b0, 16'd0, 24'd0, 24'd1, 8'd0, 24'd0, 1'b0);
    send_item(FUNC_TICK, 1'b0, 16'd0, 24'd0, 24'd1, 8'd0, 24'd0, 1'b0);
    drain_block();

    // Random phases, each under a fresh configuration.
    for (int phase = 0; phase < 6; phase++) begin
      write_reg(CFG_MAX_POWER, (phase == 0) ? 16'hFFFF : 16'($urandom));
      write_reg(CFG_MIN_POWER, (phase == 0) ? 16'd0 : 16'($urandom_range(0, 20000)));
      write_reg(CFG_MAX_S, (phase == 1) ? 16'hFFFF : 16'($urandom_range(1, 4096)));
      write_reg(CFG_SCALE, (phase == 2) ? 16'd0 : 16'($urandom_range(0, 16384)));
      write_reg(CFG_AUTO_OFF, 16'(phase % 2));
      write_reg(CFG_INVERT, 16'($urandom_range(0, 1)));
      write_reg(CFG_TTL, 16'($urandom_range(0, 1)));
      write_reg(CFG_TICK_MS, (phase == 3) ? 16'd1 : 16'($urandom_range(1, 1000)));
      if (phase == 2) hold_request = 1'b1;
      for (int n = 0; n < 100; n++) random_item();
      drain_block();
    end

    if (fail_count == 0) begin
      $display("laser_power_modulator_unit_test passed");
    end else begin
      $display("laser_power_modulator_unit_test failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("laser_power_modulator_unit_test failed");
    $finish;
  end

endmodule

/* files.f */
hdl/lpm_pkg.sv
hdl/lpm_div.sv
hdl/lpm_dp.sv
hdl/lpm_ctrl.sv
hdl/laser_power_modulator_unit.sv
tb/laser_power_modulator_unit_checker.sv
tb/laser_power_modulator_unit_test.sv
